// File: sv/bgr565_pkg.sv
// ----------------------------------------------------------------------------
// bgr565_pkg
// Shared types, constants and the RGB565 packing function for the
// BGR888-word to RGB565 converter.
// ----------------------------------------------------------------------------
package bgr565_pkg;

	localparam int unsigned WORD_W      = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HDR_W       = 10;
	localparam int unsigned POS_W       = 2;
	localparam int unsigned APB_AW      = 3;
	localparam int unsigned APB_DW      = 32;

	localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(27);
	localparam logic [HDR_W-1:0] CNT_MAX   = {HDR_W{1'b1}};

	// register index, taken from paddr[2]
	localparam logic REG_HEADER_WORDS = 1'b0;

	// byte position codes: bytes of the current triple already held
	localparam logic [POS_W-1:0] POS_BLUE  = 2'd0;
	localparam logic [POS_W-1:0] POS_GREEN = 2'd1;
	localparam logic [POS_W-1:0] POS_RED   = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              new_image;
	} word_t;

	typedef struct packed {
		logic [WORD_W-1:0] pixel;
		logic              last_in_run;
	} pix_t;

	typedef struct packed {
		logic             done;
		logic             wr_blue;
		logic             wr_green;
		logic [POS_W-1:0] pos_nxt;
	} lane_res_t;

	function automatic logic [WORD_W-1:0] pack565(
		input logic [BYTE_W-1:0] blue,
		input logic [BYTE_W-1:0] green,
		input logic [BYTE_W-1:0] red
	);
		return {red[7:3], green[7:2], blue[7:3]};
	endfunction

endpackage

// File: sv/bgr888_words_to_rgb565.sv
// A pixel enters the output register (the skid stage if output is stalled)
// when the word holding its red byte is accepted. Throughput: one word per
// cycle, set by the output register and skid stage; a stalled output stops
// input only once the skid stage fills. Reset (arst_n low) clears word count,
// byte position and the output stages, and loads header_words with 27.
// ----------------------------------------------------------------------------
// bgr888_words_to_rgb565
// Skips header words, splits each word into two byte lanes and packs every
// blue/green/red byte triple into an RGB565 pixel.
// ----------------------------------------------------------------------------
module bgr888_words_to_rgb565 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          word_valid,
	output logic                          word_ready,
	input  bgr565_pkg::word_t             word,
	output logic                          pix_valid,
	input  logic                          pix_ready,
	output bgr565_pkg::pix_t              pix,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgr565_pkg::APB_AW-1:0] paddr,
	input  logic [bgr565_pkg::APB_DW-1:0] pwdata,
	output logic [bgr565_pkg::APB_DW-1:0] prdata,
	output logic                          pready
);
	import bgr565_pkg::*;

	logic [HDR_W-1:0]  header_q;
	logic [HDR_W-1:0]  seen_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] blue_q;
	logic [BYTE_W-1:0] green_q;

	logic [HDR_W-1:0]  seen_eff;
	logic [POS_W-1:0]  pos_eff;
	logic              is_pixel_word;
	logic              accept;
	logic              skid_full;

	lane_res_t         res0, res1;
	logic [WORD_W-1:0] px0, px1;
	logic [BYTE_W-1:0] blue1, green1;
	logic [BYTE_W-1:0] byte_lo, byte_hi;
	logic              push;
	pix_t              push_data;

	// configuration port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_HEADER_WORDS) begin
			header_q <= pwdata[HDR_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_HEADER_WORDS) ?
		{{(APB_DW-HDR_W){1'b0}}, header_q} : '0;

	assign word_ready = !skid_full;
	assign accept     = word_valid && word_ready;

	// new_image takes effect before this word is counted
	assign seen_eff      = word.new_image ? '0 : seen_q;
	assign pos_eff       = word.new_image ? POS_BLUE : pos_q;
	assign is_pixel_word = seen_eff >= header_q;

	assign byte_lo = word.data_word[BYTE_W-1:0];
	assign byte_hi = word.data_word[WORD_W-1:BYTE_W];

	bgr565_lane u_lane0 (
		.pos        (pos_eff),
		.held_blue  (blue_q),
		.held_green (green_q),
		.data_byte  (byte_lo),
		.res        (res0),
		.pixel      (px0)
	);

	// high lane sees what the low lane just stored
	assign blue1  = res0.wr_blue  ? byte_lo : blue_q;
	assign green1 = res0.wr_green ? byte_lo : green_q;

	bgr565_lane u_lane1 (
		.pos        (res0.pos_nxt),
		.held_blue  (blue1),
		.held_green (green1),
		.data_byte  (byte_hi),
		.res        (res1),
		.pixel      (px1)
	);

	// merge: two bytes complete at most one triple, so that pixel is the last
	assign push                  = accept && is_pixel_word && (res0.done || res1.done);
	assign push_data.pixel       = res0.done ? px0 : px1;
	assign push_data.last_in_run = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pos_q  <= POS_BLUE;
		end else if (accept) begin
			seen_q <= (seen_eff == CNT_MAX) ? seen_eff : seen_eff + HDR_W'(1);
			pos_q  <= is_pixel_word ? res1.pos_nxt : pos_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_q  <= '0;
			green_q <= '0;
		end else if (accept && is_pixel_word) begin
			if (res1.wr_blue) begin
				blue_q <= byte_hi;
			end else if (res0.wr_blue) begin
				blue_q <= byte_lo;
			end
			if (res1.wr_green) begin
				green_q <= byte_hi;
			end else if (res0.wr_green) begin
				green_q <= byte_lo;
			end
		end
	end

	bgr565_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (skid_full),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("byte position left its range");
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !word.new_image) |=> seen_q >= $past(seen_q))
		else $error("word count went backwards without a new image");
	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pixel_word) |-> !push)
		else $error("pixel produced from a header word");
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && word.new_image) |=> (seen_q == HDR_W'(1)))
		else $error("new image did not restart the word count");
`endif

endmodule

// File: sv/bgr565_lane.sv
// ----------------------------------------------------------------------------
// bgr565_lane
// One byte lane: places a byte into the current triple and packs a pixel
// when the byte is the red one.
// ----------------------------------------------------------------------------
module bgr565_lane (
	input  logic [bgr565_pkg::POS_W-1:0]  pos,
	input  logic [bgr565_pkg::BYTE_W-1:0] held_blue,
	input  logic [bgr565_pkg::BYTE_W-1:0] held_green,
	input  logic [bgr565_pkg::BYTE_W-1:0] data_byte,
	output bgr565_pkg::lane_res_t         res,
	output logic [bgr565_pkg::WORD_W-1:0] pixel
);
	import bgr565_pkg::*;

	always_comb begin
		res = '0;
		unique case (pos)
			POS_BLUE: begin
				res.wr_blue = 1'b1;
				res.pos_nxt = POS_GREEN;
			end
			POS_GREEN: begin
				res.wr_green = 1'b1;
				res.pos_nxt  = POS_RED;
			end
			default: begin
				// red byte (a stray position also counts as red)
				res.done    = 1'b1;
				res.pos_nxt = POS_BLUE;
			end
		endcase
	end

	assign pixel = pack565(held_blue, held_green, data_byte);

endmodule

// File: sv/bgr565_skid.sv
// ----------------------------------------------------------------------------
// bgr565_skid
// Output register with a skid stage so the input side keeps flowing while
// a pixel waits to be taken.
// ----------------------------------------------------------------------------
module bgr565_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bgr565_pkg::pix_t  push_data,
	output logic              full,
	output logic              pix_valid,
	input  logic              pix_ready,
	output bgr565_pkg::pix_t  pix
);
	import bgr565_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	pix_t out_q;
	pix_t skid_q;
	logic out_free;

	assign out_free = !out_valid_q || pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end
		if (!out_free && push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign pix_valid = out_valid_q;
	assign pix       = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a pixel while the output register is empty");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("pixel pushed into a full skid stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pix_ready) |=> (out_valid_q && out_q == $past(out_q)))
		else $error("stalled pixel changed or dropped");
`endif

endmodule
